// File: src/cc2ms_pkg.sv
package cc2ms_pkg;

    localparam int unsigned COUNTER_WIDTH_DEF = 64;
    localparam int unsigned IN_WIDTH          = 64;
    localparam int unsigned RATE_WIDTH        = 23;
    localparam int unsigned REM_WIDTH         = RATE_WIDTH + 1;
    localparam int unsigned QUOT_WIDTH        = 32;
    localparam int unsigned CFG_DATA_WIDTH    = 64;
    localparam int unsigned CFG_INDEX_WIDTH   = 8;

    localparam logic [RATE_WIDTH-1:0] TICKS_PER_MS_RESET = RATE_WIDTH'(100000);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_TICKS_PER_MS = 8'd0,
        CFG_START_COUNT  = 8'd1
    } cfg_index_t;

    // Control from the end of the cell chain into the output queue
    typedef struct packed {
        logic push;
    } q_ctrl_t;

endpackage

// File: src/cc2ms_cell.sv
module cc2ms_cell
    import cc2ms_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic [RATE_WIDTH-1:0]    den,
    input  logic                     in_valid,
    input  logic [RATE_WIDTH-1:0]    in_rem,
    input  logic [COUNTER_WIDTH-1:0] in_dvd,
    input  logic [QUOT_WIDTH-1:0]    in_quot,
    output logic                     out_valid,
    output logic [RATE_WIDTH-1:0]    out_rem,
    output logic [COUNTER_WIDTH-1:0] out_dvd,
    output logic [QUOT_WIDTH-1:0]    out_quot
);

    logic                     valid_reg;
    logic [RATE_WIDTH-1:0]    rem_reg, rem_next;
    logic [COUNTER_WIDTH-1:0] dvd_reg, dvd_next;
    logic [QUOT_WIDTH-1:0]    quot_reg, quot_next;
    logic [REM_WIDTH-1:0]     trial;
    logic [REM_WIDTH-1:0]     diff;
    logic                     fits;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        trial     = {in_rem, in_dvd[COUNTER_WIDTH-1]};
        diff      = trial - {1'b0, den};
        fits      = (trial >= {1'b0, den});
        rem_next  = fits ? diff[RATE_WIDTH-1:0] : trial[RATE_WIDTH-1:0];
        dvd_next  = {in_dvd[COUNTER_WIDTH-2:0], 1'b0};
        quot_next = {in_quot[QUOT_WIDTH-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            dvd_reg  <= dvd_next;
            quot_reg <= quot_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dvd   = dvd_reg;
    assign out_quot  = quot_reg;

endmodule

// File: src/cc2ms_outq.sv
module cc2ms_outq
    import cc2ms_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  q_ctrl_t               ctrl_in,
    input  logic [QUOT_WIDTH-1:0] push_data,
    output logic                  full,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [QUOT_WIDTH-1:0] m_tdata
);

    logic [QUOT_WIDTH-1:0] mem_reg [2];
    logic [1:0]            count_reg, count_next;
    logic                  wr_ptr_reg, rd_ptr_reg;
    logic                  pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign full     = (count_reg == 2'd2);
    assign m_tdata  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({ctrl_in.push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (ctrl_in.push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_in.push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/cycle_count_to_milliseconds_top.sv
// Cycle counter to milliseconds converter.
//
// The s_ channel takes one sample of a free-running cycle counter per
// transfer (s_tdata). The block subtracts start_count, wrapping at
// COUNTER_WIDTH bits, divides by ticks_per_ms and returns the low 32 bits
// of the quotient on the m_ channel. A zero rate gives zero.
// The cfg_ channel writes index 0 (ticks_per_ms, low 23 bits used) or
// index 1 (start_count); other indexes are ignored. cfg_ready is always
// high; write only while no sample is in flight.
// Throughput: one sample per cycle while not stalled. The divider is
// a chain of COUNTER_WIDTH cells, one quotient bit per cell, behind one
// subtract stage; a sample passes it, the cells, then the output queue.
// A two-entry output queue holds finished results; the chain keeps moving
// while it has room, so input is still taken while one result waits.
// When the queue is full and m_tready is low, the chain and s_tready hold.
// Reset empties the chain and the queue and loads ticks_per_ms = 100000
// and start_count = 0.
module cycle_count_to_milliseconds_top
    import cc2ms_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [IN_WIDTH-1:0]        s_tdata,    // [63:0] counter_now
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [QUOT_WIDTH-1:0]      m_tdata,    // [31:0] elapsed_ms
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic [RATE_WIDTH-1:0]    ticks_reg;
    logic [COUNTER_WIDTH-1:0] start_reg;
    logic                     en;
    logic                     full;
    logic                     sub_valid_reg;
    logic [COUNTER_WIDTH-1:0] elapsed_reg, elapsed_next;
    q_ctrl_t                  q_ctrl;
    logic [QUOT_WIDTH-1:0]    result;

    logic                     c_valid [COUNTER_WIDTH+1];
    logic [RATE_WIDTH-1:0]    c_rem   [COUNTER_WIDTH+1];
    logic [COUNTER_WIDTH-1:0] c_dvd   [COUNTER_WIDTH+1];
    logic [QUOT_WIDTH-1:0]    c_quot  [COUNTER_WIDTH+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= TICKS_PER_MS_RESET;
            start_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TICKS_PER_MS: ticks_reg <= cfg_data[RATE_WIDTH-1:0];
                CFG_START_COUNT:  start_reg <= cfg_data[COUNTER_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    // Advance the whole chain unless the output queue is full and stalled
    assign en       = !full || m_tready;
    assign s_tready = en;

    assign elapsed_next = s_tdata[COUNTER_WIDTH-1:0] - start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_valid_reg <= 1'b0;
        end else if (en) begin
            sub_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            elapsed_reg <= elapsed_next;
        end
    end

    assign c_valid[0] = sub_valid_reg;
    assign c_rem[0]   = '0;
    assign c_dvd[0]   = elapsed_reg;
    assign c_quot[0]  = '0;

    for (genvar i = 0; i < COUNTER_WIDTH; i++) begin : g_cell
        cc2ms_cell #(
            .COUNTER_WIDTH(COUNTER_WIDTH)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .den      (ticks_reg),
            .in_valid (c_valid[i]),
            .in_rem   (c_rem[i]),
            .in_dvd   (c_dvd[i]),
            .in_quot  (c_quot[i]),
            .out_valid(c_valid[i+1]),
            .out_rem  (c_rem[i+1]),
            .out_dvd  (c_dvd[i+1]),
            .out_quot (c_quot[i+1])
        );
    end

    // User holds rate stable for samples in flight, unchecked; test last
    assign result = (ticks_reg == '0) ? '0 : c_quot[COUNTER_WIDTH];

    assign q_ctrl.push = c_valid[COUNTER_WIDTH] && en;

    cc2ms_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl_in  (q_ctrl),
        .push_data(result),
        .full     (full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: src/cc2ms_checker.sv
module cc2ms_checker
    import cc2ms_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [QUOT_WIDTH-1:0]      m_tdata,
    input logic                       cfg_valid,
    input logic                       cfg_ready
);

    // Reset drains every result
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Input backpressure only while a result is held by a stalled receiver
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result dropped or changed");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind cycle_count_to_milliseconds_top cc2ms_checker u_cc2ms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
);
